FILE: src/mmt_pkg.sv
// Shared constants, codes and control/status types for the multiset mex tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mmt_pkg;

    // Table geometry
    localparam int VALUE_SLOTS = 1024;
    localparam int BLOCK_SIZE  = 32;
    localparam int COUNT_BITS  = 16;

    localparam int NUM_BLOCKS = (VALUE_SLOTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int LAST_LEN   = VALUE_SLOTS - (NUM_BLOCKS - 1) * BLOCK_SIZE;
    localparam int ADDR_W     = $clog2(VALUE_SLOTS);
    localparam int BLK_SH     = $clog2(BLOCK_SIZE);
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int FILL_W     = $clog2(BLOCK_SIZE + 1);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int VAL_W   = 16;
    localparam int LIMIT_W = 10;
    localparam int MEX_W   = 11;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [VAL_W:0]        SLOTS_EXT   = (VAL_W + 1)'(VALUE_SLOTS);
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SEL_OLD,
        SEL_NEW,
        SEL_SCAN
    } sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_TAKE,
        S_UPD_TAKE,
        S_RD_PUT,
        S_UPD_PUT,
        S_BSCAN,
        S_VSCAN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_load;
        logic clr_wr;
        logic rd_en;
        sel_t sel;
        logic upd_en;
        logic upd_take;
        logic blk_clr;
        logic blk_inc;
        logic scan_load;
        logic scan_run;
        logic mex_hit;
        logic mex_full;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        cmd_t cmd;
        logic old_ok;
        logic new_ok;
        logic blk_open;
        logic blk_last;
        logic zero_hit;
        logic out_free;
    } sts_t;

endpackage

FILE: src/mmt_datapath.sv
// Datapath of the mex tracker: count memory, block fill registers, scan counters,
// input capture and output register. Depends on mmt_pkg.
`timescale 1ns / 1ps

module mmt_datapath import mmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output sts_t                sts,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                cfg_wen,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [COUNT_BITS-1:0] mem [VALUE_SLOTS];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [LIMIT_W-1:0] limit_reg;
    cmd_t               cmd_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [VAL_W-1:0]   nval_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic [ADDR_W-1:0] data_addr_reg;
    logic              data_valid_reg;
    logic [MEX_W-1:0]  mex_reg;
    logic              out_valid_reg;

    logic [FILL_W-1:0] fill_reg [NUM_BLOCKS];

    logic [ADDR_W-1:0]     op_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  fill_inc;
    logic                  fill_dec;
    logic [BLK_W-1:0]      upd_blk;
    logic [BLK_W-1:0]      fill_idx;
    logic [FILL_W-1:0]     fill_rd;
    logic [FILL_W-1:0]     blk_len;
    logic                  blk_last;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (ctl.in_load)
        begin
            cmd_reg  <= cmd_t'(s_tdata[CMD_W-1:0]);
            val_reg  <= s_tdata[CMD_W +: VAL_W];
            nval_reg <= s_tdata[CMD_W+VAL_W +: VAL_W];
        end
    end

    // Select the table address for the current step
    always_comb
    begin
        case (ctl.sel)
            SEL_OLD:  op_addr = val_reg[ADDR_W-1:0];
            SEL_NEW:  op_addr = nval_reg[ADDR_W-1:0];
            SEL_SCAN: op_addr = scan_addr_reg;
            default:  op_addr = val_reg[ADDR_W-1:0];
        endcase
    end

    // Saturating increment or guarded decrement of the count just read
    always_comb
    begin
        cnt_next = rd_data_reg;
        fill_inc = 1'b0;
        fill_dec = 1'b0;
        if (ctl.upd_take)
        begin
            if (rd_data_reg != '0)
            begin
                cnt_next = rd_data_reg - 1'b1;
                fill_dec = (rd_data_reg == COUNT_BITS'(1));
            end
        end
        else
        begin
            fill_inc = (rd_data_reg == '0);
            if (rd_data_reg != COUNT_MAX)
            begin
                cnt_next = rd_data_reg + 1'b1;
            end
        end
    end

    assign mem_we  = ctl.clr_wr || ctl.upd_en;
    assign wr_addr = ctl.clr_wr ? clr_addr_reg : op_addr;
    assign wr_data = ctl.clr_wr ? '0 : cnt_next;

    // Count memory, one port: write or registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[op_addr];
        end
    end

    // Clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Block fill registers, one read index shared by update and scan
    assign upd_blk  = op_addr[ADDR_W-1:BLK_SH];
    assign fill_idx = ctl.upd_en ? upd_blk : blk_reg;
    assign fill_rd  = fill_reg[fill_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (ctl.upd_en)
        begin
            if (fill_inc)
            begin
                fill_reg[upd_blk] <= fill_rd + 1'b1;
            end
            else if (fill_dec)
            begin
                fill_reg[upd_blk] <= fill_rd - 1'b1;
            end
        end
    end

    // Block scan and value scan counters
    assign blk_last = (blk_reg == BLK_W'(NUM_BLOCKS - 1));
    assign blk_len  = blk_last ? FILL_W'(LAST_LEN) : FILL_W'(BLOCK_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg        <= '0;
            scan_addr_reg  <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.blk_clr)
            begin
                blk_reg <= '0;
            end
            else if (ctl.blk_inc)
            begin
                blk_reg <= blk_reg + 1'b1;
            end
            if (ctl.scan_load)
            begin
                scan_addr_reg  <= ADDR_W'({blk_reg, {BLK_SH{1'b0}}});
                data_valid_reg <= 1'b0;
            end
            else if (ctl.scan_run)
            begin
                scan_addr_reg  <= scan_addr_reg + 1'b1;
                data_valid_reg <= 1'b1;
            end
        end
    end

    // Address of the entry whose count sits in the read register
    always_ff @(posedge clk)
    begin
        if (ctl.scan_run)
        begin
            data_addr_reg <= scan_addr_reg;
        end
    end

    // Hold the mex until the output slot frees
    always_ff @(posedge clk)
    begin
        if (ctl.mex_hit)
        begin
            mex_reg <= MEX_W'(data_addr_reg);
        end
        else if (ctl.mex_full)
        begin
            mex_reg <= MEX_W'(VALUE_SLOTS);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            m_tdata <= M_DATA_W'(mex_reg);
        end
    end

    assign m_tvalid = out_valid_reg;

    // Status back to the controller
    always_comb
    begin
        sts.clr_last = (clr_addr_reg == ADDR_W'(VALUE_SLOTS - 1));
        sts.cmd      = cmd_reg;
        sts.old_ok   = ({{(VAL_W - LIMIT_W){1'b0}}, limit_reg} >= val_reg)
                       && ({1'b0, val_reg} < SLOTS_EXT);
        sts.new_ok   = ({{(VAL_W - LIMIT_W){1'b0}}, limit_reg} >= nval_reg)
                       && ({1'b0, nval_reg} < SLOTS_EXT);
        sts.blk_open = (fill_rd < blk_len);
        sts.blk_last = blk_last;
        sts.zero_hit = data_valid_reg && (rd_data_reg == '0);
        sts.out_free = !out_valid_reg || m_tready;
    end

endmodule

FILE: src/mmt_ctrl.sv
// Sequencer of the mex tracker: clearing pass, count updates and the two-level
// mex scan. Drives the datapath through ctl_t and reads sts_t. Depends on mmt_pkg.
`timescale 1ns / 1ps

module mmt_ctrl import mmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.sel    = SEL_OLD;
        s_tready   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        state_next = sts.old_ok ? S_RD_PUT : S_IDLE;
                    end
                    CMD_REMOVE:
                    begin
                        state_next = sts.old_ok ? S_RD_TAKE : S_IDLE;
                    end
                    CMD_REPLACE:
                    begin
                        if (sts.old_ok)
                        begin
                            state_next = S_RD_TAKE;
                        end
                        else
                        begin
                            state_next = sts.new_ok ? S_RD_PUT : S_IDLE;
                        end
                    end
                    default:
                    begin
                        ctl.blk_clr = 1'b1;
                        state_next  = S_BSCAN;
                    end
                endcase
            end

            S_RD_TAKE:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_UPD_TAKE;
            end

            S_UPD_TAKE:
            begin
                ctl.upd_en   = 1'b1;
                ctl.upd_take = 1'b1;
                if (sts.cmd == CMD_REPLACE && sts.new_ok)
                begin
                    state_next = S_RD_PUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RD_PUT:
            begin
                ctl.rd_en  = 1'b1;
                ctl.sel    = (sts.cmd == CMD_REPLACE) ? SEL_NEW : SEL_OLD;
                state_next = S_UPD_PUT;
            end

            S_UPD_PUT:
            begin
                ctl.upd_en = 1'b1;
                ctl.sel    = (sts.cmd == CMD_REPLACE) ? SEL_NEW : SEL_OLD;
                state_next = S_IDLE;
            end

            // Visit one block a cycle until one is not full or the last block is full
            S_BSCAN:
            begin
                if (sts.blk_open)
                begin
                    ctl.scan_load = 1'b1;
                    state_next    = S_VSCAN;
                end
                else if (sts.blk_last)
                begin
                    ctl.mex_full = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    ctl.blk_inc = 1'b1;
                end
            end

            // Stream reads through the block; stop at the first zero count
            S_VSCAN:
            begin
                ctl.rd_en    = 1'b1;
                ctl.sel      = SEL_SCAN;
                ctl.scan_run = 1'b1;
                if (sts.zero_hit)
                begin
                    ctl.mex_hit = 1'b1;
                    state_next  = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/multiset_mex_tracker_core.sv
// Top level of the multiset mex tracker: stream ports, configuration port,
// controller and datapath. Depends on mmt_pkg, mmt_ctrl and mmt_datapath.
`timescale 1ns / 1ps

// Keeps a count for each of 1024 values plus a distinct-value count for each
// block of 32, and answers mex queries. After reset the block runs a clearing
// pass over the count memory, one entry a cycle, with s_tready low; writes to
// the value limit are taken during it. One transaction is in work at a time,
// since every step goes through the single-port count memory: insert and
// remove read and then update one count (nothing after decode when the value is
// out of range), replace does so for the old and then the new value, if in range.
// A query passes over full blocks, one block fill register a cycle (at most 31),
// then streams reads through the first open block up to its first absent value;
// when every block is full it reports 1024. A pending result in the output
// register holds the finished query until it is taken, while a waiting result
// never blocks input of updates.

module multiset_mex_tracker_core import mmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // s_tdata: cmd[1:0], value[17:2], new_value[33:18], zero pad [39:34]
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // m_tdata: mex[10:0], zero pad [15:11]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_wen,
    input  logic [LIMIT_W-1:0]  cfg_wdata
);

    ctl_t ctl;
    sts_t sts;

    // Sequencer
    mmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Storage and arithmetic
    mmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/mmt_checker.sv
// Port-level checks for the mex tracker, bound to the top level.
// Depends on mmt_pkg and multiset_mex_tracker_core.
`timescale 1ns / 1ps

module mmt_checker import mmt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // Never report a mex above the table size, never set the pad bits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= M_DATA_W'(VALUE_SLOTS)))
    else $error("mex out of range");

    // Drop ready after each accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in work");

    // No result appears after an update that is accepted while none is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[CMD_W-1:0] != CMD_QUERY) && !m_tvalid
        |=> ##1 !m_tvalid)
    else $error("result produced for an update");

endmodule

bind multiset_mex_tracker_core mmt_checker u_mmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
